// ----- hdl/dmn_pkg.sv -----
// ----------------------------------------------------------------------------
// dmn_pkg: shared types and constants of the distributed mutex node
// Beat layouts, operation and result codes, register indexes and reset
// values used by the node's modules.
// ----------------------------------------------------------------------------
package dmn_pkg;

    localparam int SEQ_W   = 32;
    localparam int RANK_W  = 5;
    localparam int NODE_W  = 4;
    localparam int CNT_W   = 5;
    localparam int DEFER_W = 16;
    localparam int CFG_W   = 5;

    // Operation codes carried by an input beat.
    localparam logic [2:0] OP_CLI_REQ    = 3'd0;
    localparam logic [2:0] OP_CLI_REL    = 3'd1;
    localparam logic [2:0] OP_CLI_DONE   = 3'd2;
    localparam logic [2:0] OP_PEER_REQ   = 3'd3;
    localparam logic [2:0] OP_PEER_REPLY = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_GRANT = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MY_INDEX    = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT  = 2'd1;
    localparam logic [1:0] CFG_CLIENT_RANK = 2'd2;

    localparam logic [NODE_W-1:0] MY_INDEX_RST    = 4'd0;
    localparam logic [CNT_W-1:0]  NODE_COUNT_RST  = 5'd16;
    localparam logic [RANK_W-1:0] CLIENT_RANK_RST = 5'd1;

    typedef struct packed {
        logic [2:0]        operation;
        logic [NODE_W-1:0] sender_index;
        logic [SEQ_W-1:0]  seq_num;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [RANK_W-1:0] dest_rank;
        logic [SEQ_W-1:0]  out_seq;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] my_index;
        logic [CNT_W-1:0]  node_count;
        logic [RANK_W-1:0] client_rank;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
    } scan_ctl_t;

    typedef struct packed {
        logic [RANK_W-1:0] idx;
        logic              last;
    } scan_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CMP_OWN,
        ST_EMIT,
        ST_SCAN
    } state_t;

    // Destination rank of a peer: twice its server index, kept to five bits.
    function automatic logic [RANK_W-1:0] peer_rank(input logic [RANK_W-1:0] idx);
        peer_rank = {idx[RANK_W-2:0], 1'b0};
    endfunction

endpackage

// ----- hdl/dmn_scan.sv -----
// ----------------------------------------------------------------------------
// dmn_scan: peer walker
// Holds a mask of peers still to be addressed and hands out the lowest one
// per step, flagging the final peer.
// ----------------------------------------------------------------------------
module dmn_scan #(
    parameter int W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dmn_pkg::scan_ctl_t   ctl,
    input  logic [W-1:0]         load_mask,
    output dmn_pkg::scan_stat_t  stat
);
    import dmn_pkg::*;

    logic [W-1:0]      mask_reg;
    logic [W-1:0]      mask_next;
    logic [W-1:0]      low;
    logic [W-1:0]      rest;
    logic [RANK_W-1:0] idx;

    // Isolate the lowest set bit, then encode it.
    assign low  = mask_reg & (~mask_reg + W'(1));
    assign rest = mask_reg & ~low;

    always_comb begin
        idx = '0;
        for (int i = 0; i < W; i++) begin
            if (low[i]) begin
                idx = idx | RANK_W'(i);
            end
        end
    end

    assign stat.idx  = idx;
    assign stat.last = (rest == '0);

    always_comb begin
        mask_next = mask_reg;
        if (ctl.load) begin
            mask_next = load_mask;
        end else if (ctl.step) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

`ifndef SYNTHESIS
    a_step_has_peer: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.step |-> (mask_reg != '0))
        else $error("scan stepped with no peer left");

    a_no_load_and_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.load && ctl.step))
        else $error("scan loaded and stepped together");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.step && stat.last) |=> (mask_reg == '0))
        else $error("scan mask not empty after final peer");
`endif

endmodule

// ----- hdl/dmn_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmn_ctrl: protocol sequencer
// Decodes one beat at a time, keeps the lock state, shares one sequence
// comparator between its steps and drives the peer walker.
// ----------------------------------------------------------------------------
module dmn_ctrl #(
    parameter int SCAN_W  = 16,
    parameter int CNT_MAX = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dmn_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dmn_pkg::in_item_t    s_data,
    input  logic                 out_free,
    output logic                 emit_valid,
    output dmn_pkg::out_item_t   emit_data,
    output dmn_pkg::scan_ctl_t   scan_ctl,
    output logic [SCAN_W-1:0]    scan_mask,
    input  dmn_pkg::scan_stat_t  scan_stat
);
    import dmn_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(CNT_MAX);
    localparam int RST_CNT = (CNT_MAX < int'(NODE_COUNT_RST)) ? CNT_MAX : int'(NODE_COUNT_RST);
    localparam logic [CNT_W-1:0] REPLIES_RST = CNT_W'(RST_CNT - 1);

    state_t              state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [NODE_W-1:0]   sender_reg, sender_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [SEQ_W-1:0]    own_seq_reg, own_seq_next;
    logic [SEQ_W-1:0]    highest_seq_reg, highest_seq_next;
    logic                pending_reg, pending_next;
    logic [CNT_W-1:0]    replies_reg, replies_next;
    logic [DEFER_W-1:0]  deferred_reg, deferred_next;
    out_item_t           res_reg, res_next;
    logic [1:0]          scan_kind_reg, scan_kind_next;

    logic [CNT_W-1:0]    cnt;
    logic [SEQ_W-1:0]    cmp_b;
    logic                cmp_gt;
    logic                cmp_eq;
    logic [SCAN_W-1:0]   bcast_mask;
    logic [SCAN_W-1:0]   flush_mask;
    out_item_t           err_item;
    out_item_t           grant_item;

    // Node count in use, clamped to 1..CNT_LIM.
    always_comb begin
        if (cfg.node_count == '0) begin
            cnt = CNT_W'(1);
        end else if (cfg.node_count > CNT_LIM) begin
            cnt = CNT_LIM;
        end else begin
            cnt = cfg.node_count;
        end
    end

    // The one sequence comparator: against highest_seq while decoding,
    // against own_seq in the priority step.
    assign cmp_b  = (state_reg == ST_CMP_OWN) ? own_seq_reg : highest_seq_reg;
    assign cmp_gt = (seq_reg > cmp_b);
    assign cmp_eq = (seq_reg == cmp_b);

    always_comb begin
        for (int i = 0; i < SCAN_W; i++) begin
            bcast_mask[i] = (CNT_W'(i) < cnt) && (CNT_W'(i) != {1'b0, cfg.my_index});
            if (i < DEFER_W) begin
                flush_mask[i] = deferred_reg[i] && (CNT_W'(i) != {1'b0, cfg.my_index});
            end else begin
                flush_mask[i] = 1'b0;
            end
        end
    end

    assign err_item   = '{kind: KIND_ERR, dest_rank: '0, out_seq: '0, last: 1'b1};
    assign grant_item = '{kind: KIND_GRANT, dest_rank: cfg.client_rank, out_seq: '0,
                          last: 1'b1};

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        sender_next      = sender_reg;
        seq_next         = seq_reg;
        own_seq_next     = own_seq_reg;
        highest_seq_next = highest_seq_reg;
        pending_next     = pending_reg;
        replies_next     = replies_reg;
        deferred_next    = deferred_reg;
        res_next         = res_reg;
        scan_kind_next   = scan_kind_reg;
        emit_valid       = 1'b0;
        emit_data        = res_reg;
        scan_ctl         = '0;
        scan_mask        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_data.operation;
                    sender_next = s_data.sender_index;
                    seq_next    = s_data.seq_num;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE: begin
                state_next = ST_IDLE;
                case (op_reg)
                    OP_CLI_REQ: begin
                        if (pending_reg || ({1'b0, cfg.my_index} >= cnt)) begin
                            res_next   = err_item;
                            state_next = ST_EMIT;
                        end else begin
                            pending_next = 1'b1;
                            replies_next = cnt - CNT_W'(1);
                            own_seq_next = (&highest_seq_reg) ? highest_seq_reg
                                                              : highest_seq_reg + SEQ_W'(1);
                            if (cnt == CNT_W'(1)) begin
                                res_next   = grant_item;
                                state_next = ST_EMIT;
                            end else begin
                                scan_ctl.load  = 1'b1;
                                scan_mask      = bcast_mask;
                                scan_kind_next = KIND_REQ;
                                state_next     = ST_SCAN;
                            end
                        end
                    end
                    OP_CLI_REL: begin
                        if (!pending_reg) begin
                            res_next   = err_item;
                            state_next = ST_EMIT;
                        end else begin
                            pending_next  = 1'b0;
                            replies_next  = cnt - CNT_W'(1);
                            deferred_next = '0;
                            if (flush_mask != '0) begin
                                scan_ctl.load  = 1'b1;
                                scan_mask      = flush_mask;
                                scan_kind_next = KIND_REPLY;
                                state_next     = ST_SCAN;
                            end
                        end
                    end
                    OP_CLI_DONE: begin
                        state_next = ST_IDLE;
                    end
                    OP_PEER_REQ: begin
                        if (({1'b0, sender_reg} >= cnt) || (sender_reg == cfg.my_index)) begin
                            res_next   = err_item;
                            state_next = ST_EMIT;
                        end else begin
                            if (cmp_gt) begin
                                highest_seq_next = seq_reg;
                            end
                            state_next = ST_CMP_OWN;
                        end
                    end
                    OP_PEER_REPLY: begin
                        if (!pending_reg || (replies_reg == '0)) begin
                            res_next   = err_item;
                            state_next = ST_EMIT;
                        end else begin
                            replies_next = replies_reg - CNT_W'(1);
                            if (replies_reg == CNT_W'(1)) begin
                                res_next   = grant_item;
                                state_next = ST_EMIT;
                            end
                        end
                    end
                    default: begin
                        res_next   = err_item;
                        state_next = ST_EMIT;
                    end
                endcase
            end

            ST_CMP_OWN: begin
                // Defer when our own request outranks the peer's.
                if (pending_reg && (cmp_gt || (cmp_eq && (sender_reg > cfg.my_index)))) begin
                    deferred_next = deferred_reg | (DEFER_W'(1) << sender_reg);
                    state_next    = ST_IDLE;
                end else begin
                    res_next   = '{kind: KIND_REPLY,
                                   dest_rank: peer_rank({1'b0, sender_reg}),
                                   out_seq: '0, last: 1'b1};
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                emit_valid = 1'b1;
                emit_data  = res_reg;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN: begin
                emit_valid          = 1'b1;
                emit_data.kind      = scan_kind_reg;
                emit_data.dest_rank = peer_rank(scan_stat.idx);
                emit_data.out_seq   = (scan_kind_reg == KIND_REQ) ? own_seq_reg : '0;
                emit_data.last      = scan_stat.last;
                scan_ctl.step       = out_free;
                if (out_free && scan_stat.last) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            own_seq_reg     <= '0;
            highest_seq_reg <= '0;
            pending_reg     <= 1'b0;
            replies_reg     <= REPLIES_RST;
            deferred_reg    <= '0;
        end else begin
            state_reg       <= state_next;
            own_seq_reg     <= own_seq_next;
            highest_seq_reg <= highest_seq_next;
            pending_reg     <= pending_next;
            replies_reg     <= replies_next;
            deferred_reg    <= deferred_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        sender_reg    <= sender_next;
        seq_reg       <= seq_next;
        res_reg       <= res_next;
        scan_kind_reg <= scan_kind_next;
    end

`ifndef SYNTHESIS
    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat is in work");

    a_replies_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        replies_reg <= (CNT_LIM - CNT_W'(1)))
        else $error("awaited reply count beyond node count");
`endif

endmodule

// ----- hdl/distributed_mutex_node.sv -----
// ----------------------------------------------------------------------------
// distributed_mutex_node: one node of a Ricart-Agrawala distributed lock
// Configuration registers, result output register and the sequencer with
// its peer walker.
// ----------------------------------------------------------------------------
// The node takes one beat at a time: s_ready is high only while it is idle.
// Each beat is captured and then decoded; a peer request also passes the
// sequence comparator to settle priority. Every result then goes through
// the output register, which holds it while the consumer keeps m_ready
// low. A client request sends one request beat to each other node in index
// order, and a release sends one reply beat to each deferred peer in index
// order; the final beat for each input carries last. Protocol misuse
// gives a single error beat and leaves the lock state untouched.
// Configuration writes take effect at once and must only be issued while
// the node is idle.
// ----------------------------------------------------------------------------
module distributed_mutex_node #(
    parameter int MAX_NODES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [dmn_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dmn_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dmn_pkg::out_item_t                  m_data
);
    import dmn_pkg::*;

    // Node counts are five bits wide, so the usable count tops out at 31.
    localparam int CNT_MAX = (MAX_NODES > 31) ? 31 : MAX_NODES;
    // The walker mask covers every possible peer and every deferred bit.
    localparam int SCAN_W  = (CNT_MAX > DEFER_W) ? CNT_MAX : DEFER_W;

    cfg_t        cfg_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    logic        out_free;
    logic        emit_valid;
    out_item_t   emit_data;
    scan_ctl_t   scan_ctl;
    scan_stat_t  scan_stat;
    logic [SCAN_W-1:0] scan_mask;

    // Configuration registers. An index past the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.my_index    <= MY_INDEX_RST;
            cfg_reg.node_count  <= NODE_COUNT_RST;
            cfg_reg.client_rank <= CLIENT_RANK_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MY_INDEX:    cfg_reg.my_index    <= cfg_wdata[NODE_W-1:0];
                CFG_NODE_COUNT:  cfg_reg.node_count  <= cfg_wdata[CNT_W-1:0];
                CFG_CLIENT_RANK: cfg_reg.client_rank <= cfg_wdata[RANK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer only hands over a result when the output register is
    // empty or its beat is leaving in this cycle.
    assign out_free = !m_valid_reg || m_ready;

    dmn_ctrl #(
        .SCAN_W  (SCAN_W),
        .CNT_MAX (CNT_MAX)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit_data  (emit_data),
        .scan_ctl   (scan_ctl),
        .scan_mask  (scan_mask),
        .scan_stat  (scan_stat)
    );

    dmn_scan #(
        .W (SCAN_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .load_mask (scan_mask),
        .stat      (scan_stat)
    );

    // Output register: holds a result beat until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && emit_valid) begin
            m_data_reg <= emit_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- tb/dmn_lock_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmn_lock_checker: result predictor and scoreboard for the mutex node
// Watches the register port and both beat channels. It keeps its own copy of
// the lock state, queues the messages each accepted beat should cause, and
// compares every result beat with the oldest one queued.
// ----------------------------------------------------------------------------
module dmn_lock_checker #(
    parameter int MAX_NODES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [dmn_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  dmn_pkg::in_item_t          s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  dmn_pkg::out_item_t         m_data,
    output int                         fail_count,
    output int                         msgs_waiting
);

    import dmn_pkg::*;

    logic [NODE_W-1:0]  cfg_me;
    logic [CNT_W-1:0]   cfg_count;
    logic [RANK_W-1:0]  cfg_rank;

    logic [SEQ_W-1:0]   seq_mine;
    logic [SEQ_W-1:0]   seq_seen;
    logic               lock_wanted;
    logic [CNT_W-1:0]   acks_left;
    logic [DEFER_W-1:0] held_peers;

    out_item_t msgs_due[$];

    initial begin
        fail_count   = 0;
        msgs_waiting = 0;
    end

    // Node count as the lock uses it: clamped to 1..MAX_NODES.
    function automatic int unsigned node_span();
        if (cfg_count == 0) return 1;
        if (cfg_count > MAX_NODES) return MAX_NODES;
        return cfg_count;
    endfunction

    function automatic out_item_t build_msg(input logic [1:0] kind,
                                            input logic [RANK_W-1:0] dest,
                                            input logic [SEQ_W-1:0] seq);
        out_item_t msg;
        msg.kind      = kind;
        msg.dest_rank = dest;
        msg.out_seq   = seq;
        msg.last      = 1'b0;
        return msg;
    endfunction

    task automatic report_failure(input string msg);
        $display("%0t dmn_lock_checker: %s", $time, msg);
        fail_count++;
    endtask

    // Works out the messages one accepted beat causes and updates the lock.
    task automatic apply_lock_beat(input in_item_t b);
        out_item_t    burst [0:MAX_NODES];
        int           n;
        int unsigned  span;
        int unsigned  i;
        logic         defer;
        n    = 0;
        span = node_span();
        case (b.operation)
            OP_CLI_REQ: begin
                if (lock_wanted || cfg_me >= span) begin
                    burst[n++] = build_msg(KIND_ERR, '0, '0);
                end else begin
                    lock_wanted = 1'b1;
                    acks_left   = CNT_W'(span - 1);
                    seq_mine    = (seq_seen == '1) ? seq_seen : seq_seen + 1;
                    for (i = 0; i < span; i++) begin
                        if (i != cfg_me)
                            burst[n++] = build_msg(KIND_REQ, RANK_W'(i * 2), seq_mine);
                    end
                    if (acks_left == 0) burst[n++] = build_msg(KIND_GRANT, cfg_rank, '0);
                end
            end
            OP_CLI_REL: begin
                if (!lock_wanted) begin
                    burst[n++] = build_msg(KIND_ERR, '0, '0);
                end else begin
                    lock_wanted = 1'b0;
                    acks_left   = CNT_W'(span - 1);
                    for (i = 0; i < MAX_NODES; i++) begin
                        if (i != cfg_me && held_peers[i])
                            burst[n++] = build_msg(KIND_REPLY, RANK_W'(i * 2), '0);
                    end
                    held_peers = '0;
                end
            end
            OP_CLI_DONE: begin
            end
            OP_PEER_REQ: begin
                if (b.sender_index >= span || b.sender_index == cfg_me) begin
                    burst[n++] = build_msg(KIND_ERR, '0, '0);
                end else begin
                    if (b.seq_num > seq_seen) seq_seen = b.seq_num;
                    // The peer waits if our own request ranks ahead of it.
                    defer = lock_wanted && (b.seq_num > seq_mine ||
                            (b.seq_num == seq_mine && b.sender_index > cfg_me));
                    if (defer)
                        held_peers[b.sender_index] = 1'b1;
                    else
                        burst[n++] = build_msg(KIND_REPLY,
                                               RANK_W'(b.sender_index * 2), '0);
                end
            end
            OP_PEER_REPLY: begin
                if (!lock_wanted || acks_left == 0) begin
                    burst[n++] = build_msg(KIND_ERR, '0, '0);
                end else begin
                    acks_left--;
                    if (acks_left == 0) burst[n++] = build_msg(KIND_GRANT, cfg_rank, '0);
                end
            end
            default: begin
                burst[n++] = build_msg(KIND_ERR, '0, '0);
            end
        endcase
        if (n > 0) burst[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) msgs_due.push_back(burst[k]);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (msgs_due.size() == 0) begin
            report_failure($sformatf("result beat with nothing expected: kind %0d dest %0d",
                                     got.kind, got.dest_rank));
        end else begin
            want = msgs_due.pop_front();
            if (got.kind != want.kind)
                report_failure($sformatf("kind got %0d, expected %0d", got.kind, want.kind));
            if (got.dest_rank != want.dest_rank)
                report_failure($sformatf("dest_rank got %0d, expected %0d",
                                         got.dest_rank, want.dest_rank));
            if (got.out_seq != want.out_seq)
                report_failure($sformatf("out_seq got 0x%08h, expected 0x%08h",
                                         got.out_seq, want.out_seq));
            if (got.last != want.last)
                report_failure($sformatf("last got %0b, expected %0b", got.last, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_me      = MY_INDEX_RST;
            cfg_count   = NODE_COUNT_RST;
            cfg_rank    = CLIENT_RANK_RST;
            seq_mine    = '0;
            seq_seen    = '0;
            lock_wanted = 1'b0;
            acks_left   = CNT_W'(node_span() - 1);
            held_peers  = '0;
            msgs_due.delete();
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MY_INDEX:    cfg_me    = cfg_wdata[NODE_W-1:0];
                    CFG_NODE_COUNT:  cfg_count = cfg_wdata[CNT_W-1:0];
                    CFG_CLIENT_RANK: cfg_rank  = cfg_wdata[RANK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) apply_lock_beat(s_data);
        end
        msgs_waiting = msgs_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the distributed mutex node
// Runs a directed pass over the protocol corner cases, then phases of lock
// sessions with random content under several idle and stall patterns. The
// checker beside the node predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

    import dmn_pkg::*;

    // Cycles allowed after the last expected beat for work that makes no
    // result, such as a deferred peer request or a release with nothing held.
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 40000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    in_item_t          s_data    = '0;
    logic              s_ready;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;

    int fail_count;
    int msgs_waiting;

    // Idle and stall odds, in percent per cycle, set by each phase.
    int idle_pct   = 0;
    int stall_pct  = 0;
    int beats_sent = 0;

    // Rough mirror of the node, used only to steer the stimulus toward
    // interesting comparisons. The checker keeps the exact state.
    logic [NODE_W-1:0] me_now   = MY_INDEX_RST;
    int unsigned       span_now = 16;
    logic [SEQ_W-1:0]  seq_top  = '0;
    logic [SEQ_W-1:0]  my_seq   = '0;

    always #10 aclk = ~aclk;

    distributed_mutex_node dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    dmn_lock_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .msgs_waiting (msgs_waiting)
    );

    // The consumer decides afresh at each falling edge whether to take a beat.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one beat and returns once it has been accepted. Valid stays high
    // afterwards; the next call either replaces the payload or idles first.
    task automatic send_beat(input logic [2:0] op, input logic [NODE_W-1:0] sender,
                             input logic [SEQ_W-1:0] seq);
        in_item_t beat;
        beat.operation    = op;
        beat.sender_index = sender;
        beat.seq_num      = seq;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        // Keep the steering mirror roughly in step with the node.
        if (op == OP_PEER_REQ && sender < span_now && sender != me_now && seq > seq_top)
            seq_top = seq;
        if (op == OP_CLI_REQ)
            my_seq = (seq_top == '1) ? seq_top : seq_top + 1;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MY_INDEX) me_now = val[NODE_W-1:0];
        if (idx == CFG_NODE_COUNT) span_now = (val == 0) ? 1 : (val > 16 ? 16 : val);
    endtask

    task automatic set_config(input logic [NODE_W-1:0] me, input logic [CNT_W-1:0] cnt,
                              input logic [RANK_W-1:0] rank);
        write_reg(CFG_MY_INDEX, CFG_W'(me));
        write_reg(CFG_NODE_COUNT, cnt);
        write_reg(CFG_CLIENT_RANK, rank);
    endtask

    // Stops offering beats and waits until every expected result has been
    // taken, then leaves the node time to finish any silent work.
    task automatic drain_results();
        int guard;
        @(negedge aclk);
        s_valid <= 1'b0;
        guard = 0;
        while (msgs_waiting != 0 && guard < DRAIN_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // A legal peer request whose sequence number sits near our own, so the
    // node has to settle priority both by number and by index.
    task automatic send_peer_request();
        logic [NODE_W-1:0] peer;
        logic [SEQ_W-1:0]  seq;
        if (span_now < 2) return;
        do peer = NODE_W'($urandom_range(span_now - 1)); while (peer == me_now);
        case ($urandom_range(3))
            0:       seq = (my_seq == 0) ? my_seq : my_seq - 1;
            1:       seq = my_seq;
            2:       seq = my_seq + 1;
            default: seq = seq_top + $urandom_range(2);
        endcase
        send_beat(OP_PEER_REQ, peer, seq);
    endtask

    // Any operation code with random fields. A legal peer request keeps a
    // modest sequence number so the lock does not saturate early.
    task automatic send_noise();
        logic [2:0]        op;
        logic [NODE_W-1:0] sender;
        logic [SEQ_W-1:0]  seq;
        op     = 3'($urandom_range(7));
        sender = NODE_W'($urandom_range(15));
        seq    = $urandom();
        if (op == OP_PEER_REQ && sender < span_now && sender != me_now)
            seq = seq_top + $urandom_range(3);
        send_beat(op, sender, seq);
    endtask

    // One phase: a register setting with idle and stall odds, then whole lock
    // sessions (request, replies with peer traffic mixed in, release) until
    // enough beats have gone in.
    task automatic run_phase(input int idle, input int stall, input logic [NODE_W-1:0] me,
                             input logic [CNT_W-1:0] cnt, input logic [RANK_W-1:0] rank,
                             input int beats);
        int goal;
        drain_results();
        set_config(me, cnt, rank);
        idle_pct  = idle;
        stall_pct = stall;
        goal      = beats_sent + beats;
        while (beats_sent < goal) begin
            if ($urandom_range(99) < 10) send_noise();
            send_beat(OP_CLI_REQ, NODE_W'($urandom_range(15)), $urandom());
            for (int r = 1; r < span_now; r++) begin
                while ($urandom_range(99) < 30) send_peer_request();
                if ($urandom_range(99) < 8) send_noise();
                send_beat(OP_PEER_REPLY, NODE_W'($urandom_range(15)), $urandom());
            end
            // Requests arriving while the lock is held are mostly deferred.
            if ($urandom_range(99) < 50) send_peer_request();
            if ($urandom_range(99) < 30)
                send_beat(OP_CLI_DONE, NODE_W'($urandom_range(15)), $urandom());
            send_beat(OP_CLI_REL, NODE_W'($urandom_range(15)), $urandom());
            if ($urandom_range(99) < 10)
                send_beat(OP_CLI_REL, NODE_W'($urandom_range(15)), $urandom());
            // Now and then the sender holds off until the node has gone quiet.
            if ($urandom_range(99) < 15) drain_results();
        end
    endtask

    // Run limit, well above the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset settings: index 0 of sixteen nodes, client rank 1.
        send_beat(OP_CLI_DONE, 4'd7, 32'h0);            // nothing happens
        send_beat(OP_CLI_REL, 4'd0, 32'h0);             // release while idle
        send_beat(OP_PEER_REPLY, 4'd1, 32'h0);          // reply while idle
        send_beat(OP_PEER_REQ, 4'd0, 32'hFFFF_FFFF);    // request from own index
        send_beat(3'd5, 4'd15, 32'hAAAA_5555);          // unknown operations
        send_beat(3'd6, 4'd0, 32'h0);
        send_beat(3'd7, 4'd15, 32'h5555_AAAA);
        send_beat(OP_PEER_REQ, 4'd15, 32'd10);          // answered at once
        send_beat(OP_CLI_REQ, 4'd0, 32'h0);             // full broadcast, seq 11
        send_beat(OP_CLI_REQ, 4'd0, 32'h0);             // request while pending
        send_beat(OP_PEER_REQ, 4'd3, 32'd12);           // later seq: deferred
        send_beat(OP_PEER_REQ, 4'd9, 32'd11);           // tie, higher index: deferred
        send_beat(OP_PEER_REQ, 4'd4, 32'd5);            // earlier seq: answered
        send_beat(OP_CLI_REL, 4'd0, 32'h0);             // flush of the deferred pair
        send_beat(OP_CLI_REL, 4'd0, 32'h0);             // release while idle

        // A lone node is granted straight away.
        drain_results();
        set_config(4'd0, 5'd1, 5'd31);
        send_beat(OP_CLI_REQ, 4'd0, 32'h0);
        send_beat(OP_PEER_REQ, 4'd1, 32'd3);            // sender beyond node count
        send_beat(OP_PEER_REPLY, 4'd0, 32'h0);          // no replies awaited
        send_beat(OP_CLI_REL, 4'd0, 32'h0);             // nothing deferred: silent

        // A node count of zero acts as one, and leaves index 15 outside it.
        drain_results();
        set_config(4'd15, 5'd0, 5'd0);
        send_beat(OP_CLI_REQ, 4'd0, 32'h0);
        send_beat(OP_PEER_REQ, 4'd0, 32'd0);

        // Three nodes: grant after both replies, then the held peer is the
        // node's own new index by the time of the release, so it is dropped.
        drain_results();
        set_config(4'd1, 5'd3, 5'd0);
        send_beat(OP_CLI_REQ, 4'd0, 32'h0);
        send_beat(OP_PEER_REQ, 4'd2, 32'd13);
        send_beat(OP_PEER_REPLY, 4'd0, 32'h0);
        send_beat(OP_PEER_REPLY, 4'd0, 32'h0);
        drain_results();
        write_reg(CFG_MY_INDEX, 5'd2);
        send_beat(OP_CLI_REL, 4'd0, 32'h0);

        // Random sessions under each idle and stall pattern.
        run_phase(0, 0, 4'd7, 5'd31, 5'd31, 40);
        run_phase(80, 0, 4'd15, 5'd16, 5'd0, 40);
        run_phase(0, 80, 4'd2, 5'd5, 5'd17, 40);
        run_phase(37, 37, 4'd0, 5'd2, 5'd9, 40);

        // Saturation of the sequence number, kept for last since the highest
        // sequence seen never falls again.
        send_beat(OP_CLI_REL, 4'd0, 32'h0);
        send_beat(OP_PEER_REQ, 4'd1, 32'hFFFF_FFFF);
        send_beat(OP_CLI_REQ, 4'd0, 32'h0);
        send_beat(OP_PEER_REQ, 4'd1, 32'hFFFF_FFFF);
        send_beat(OP_PEER_REPLY, 4'd0, 32'h0);
        send_beat(OP_CLI_REL, 4'd0, 32'h0);
        send_beat(OP_CLI_REQ, 4'd0, 32'h0);
        send_beat(OP_PEER_REPLY, 4'd0, 32'h0);
        send_beat(OP_CLI_REL, 4'd0, 32'h0);

        drain_results();
        if (fail_count == 0 && msgs_waiting == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dmn_pkg.sv
hdl/dmn_scan.sv
hdl/dmn_ctrl.sv
hdl/distributed_mutex_node.sv
tb/dmn_lock_checker.sv
tb/tb_top.sv
